@@ hw/rtl/rabc_pkg.sv @@
package rabc_pkg;

  localparam int NUM_REGIONS     = 5;
  localparam int ADDR_WIDTH      = 32;
  localparam int WRITABLE_COUNT  = 3;
  localparam int SIZE_WIDTH      = 32;
  localparam int REGION_WIDTH    = 64;
  localparam int CFG_INDEX_WIDTH = 3;

  // commands
  localparam logic [1:0] CMD_ACCESS   = 2'd0;
  localparam logic [1:0] CMD_STR_START = 2'd1;
  localparam logic [1:0] CMD_STR_BYTE = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  // answer kinds
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_STRING = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SANDBOXED = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEAP      = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STACK     = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DATA      = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CODE      = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VENEER    = 3'd5;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [ADDR_WIDTH-1:0] address;
    logic [31:0]           length;
    logic                  is_write;
    logic [7:0]            char_byte;
  } in_t;

  typedef struct packed {
    logic        answer_kind;
    logic        allowed;
    logic [31:0] string_length;
  } out_t;

  typedef logic [NUM_REGIONS-1:0][REGION_WIDTH-1:0] region_array_t;

  typedef struct packed {
    logic                  span_hit;
    logic                  span_writable;
    logic                  start_hit;
    logic [SIZE_WIDTH-1:0] start_room;
  } match_t;

endpackage

@@ hw/rtl/rabc_region_match.sv @@
module rabc_region_match (
  input  rabc_pkg::region_array_t       regions,
  input  logic [rabc_pkg::ADDR_WIDTH-1:0] address,
  input  logic [31:0]                     length,
  output rabc_pkg::match_t                match
);

  logic [rabc_pkg::ADDR_WIDTH-1:0] base [rabc_pkg::NUM_REGIONS];
  logic [rabc_pkg::SIZE_WIDTH-1:0] size [rabc_pkg::NUM_REGIONS];
  logic [rabc_pkg::SIZE_WIDTH-1:0] off  [rabc_pkg::NUM_REGIONS];
  logic [rabc_pkg::SIZE_WIDTH-1:0] room [rabc_pkg::NUM_REGIONS];
  logic [rabc_pkg::NUM_REGIONS-1:0] span_ok;
  logic [rabc_pkg::NUM_REGIONS-1:0] start_ok;

  // per region compares, all in parallel
  always_comb begin
    for (int i = 0; i < rabc_pkg::NUM_REGIONS; i++) begin
      base[i] = regions[i][32 +: rabc_pkg::ADDR_WIDTH];
      size[i] = regions[i][rabc_pkg::SIZE_WIDTH-1:0];
      off[i]  = rabc_pkg::SIZE_WIDTH'(address - base[i]);
      room[i] = size[i] - off[i];
      span_ok[i]  = (size[i] != '0) && (address >= base[i]) && (off[i] <= size[i])
                    && (length <= room[i]);
      start_ok[i] = (size[i] != '0) && (address >= base[i]) && (off[i] < size[i]);
    end
  end

  // first region in list order wins
  always_comb begin
    match = '0;
    for (int i = rabc_pkg::NUM_REGIONS - 1; i >= 0; i--) begin
      if (span_ok[i]) begin
        match.span_hit      = 1'b1;
        match.span_writable = (i < rabc_pkg::WRITABLE_COUNT);
      end
    end
    for (int i = rabc_pkg::NUM_REGIONS - 1; i >= 0; i--) begin
      if (start_ok[i]) begin
        match.start_hit  = 1'b1;
        match.start_room = room[i];
      end
    end
  end

endmodule

@@ hw/rtl/region_access_and_string_bound_check.sv @@
// region access and string bound checker
// input channel: in_valid / in_stall carry one command word (access check,
// string start or string byte); a word is taken on a clock edge with valid
// high and stall low
// output channel: out_valid / out_stall carry one answer word; access checks
// always answer, string start answers only on immediate refusal or when
// unsandboxed, string bytes answer when the scan ends
// config port: cfg_write with cfg_index and cfg_data writes one register
// (0 sandboxed, 1..5 heap, stack, data, code, veneer); the user must write
// only while idle; the block itself does not enforce this
// throughput: one word per cycle while the answer register is not held; the
// five region compares run in parallel between input and answer registers
// stall: when the answer register is held, the input register holds its word
// and in_stall goes high only while that register is full
// reset: rst (synchronous) clears the configuration registers to zero,
// the scan state and both valid flags
module region_access_and_string_bound_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rabc_pkg::in_t                       in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rabc_pkg::out_t                      out_word,
  input  logic                                cfg_write,
  input  logic [rabc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rabc_pkg::REGION_WIDTH-1:0]   cfg_data
);

  // configuration registers
  logic                    sandboxed;
  rabc_pkg::region_array_t regions;

  // input register
  logic          s1_valid;
  rabc_pkg::in_t s1_word;

  // string scan state
  logic        scan_active;
  logic [31:0] scan_room;
  logic [31:0] scan_count;
  logic        scan_active_next;
  logic [31:0] scan_room_next;
  logic [31:0] scan_count_next;

  // answer computed from the input register
  logic           produce;
  rabc_pkg::out_t result;
  rabc_pkg::match_t match;

  logic        advance;
  logic [31:0] count_inc;

  // the input register moves on when the answer register is free or drained
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sandboxed <= 1'b0;
      regions   <= '0;
    end else if (cfg_write) begin
      if (cfg_index == rabc_pkg::REG_SANDBOXED) begin
        sandboxed <= cfg_data[0];
      end
      for (int i = 0; i < rabc_pkg::NUM_REGIONS; i++) begin
        if (cfg_index == rabc_pkg::CFG_INDEX_WIDTH'(rabc_pkg::REG_HEAP + i)) begin
          regions[i] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_word <= in_word;
    end
  end

  rabc_region_match u_match (
    .regions (regions),
    .address (s1_word.address),
    .length  (s1_word.length),
    .match   (match)
  );

  assign count_inc = scan_count + 32'd1;

  always_comb begin
    produce          = 1'b0;
    result           = '0;
    scan_active_next = scan_active;
    scan_room_next   = scan_room;
    scan_count_next  = scan_count;
    case (s1_word.cmd)
      rabc_pkg::CMD_ACCESS: begin
        produce            = 1'b1;
        result.answer_kind = rabc_pkg::KIND_ACCESS;
        if (!sandboxed || s1_word.length == '0) begin
          result.allowed = 1'b1;
        end else if (s1_word.address != '0 && match.span_hit) begin
          // writes into code or veneer are refused
          result.allowed = !(s1_word.is_write && !match.span_writable);
        end
      end
      rabc_pkg::CMD_STR_START: begin
        // a restart drops any scan in flight without answering it
        scan_active_next   = 1'b0;
        scan_count_next    = '0;
        scan_room_next     = '0;
        result.answer_kind = rabc_pkg::KIND_STRING;
        if (!sandboxed) begin
          produce        = 1'b1;
          result.allowed = (s1_word.address != '0);
        end else if (s1_word.address == '0 || !match.start_hit) begin
          produce = 1'b1;
        end else begin
          scan_active_next = 1'b1;
          scan_room_next   = match.start_room;
        end
      end
      rabc_pkg::CMD_STR_BYTE: begin
        result.answer_kind = rabc_pkg::KIND_STRING;
        if (scan_active) begin
          if (s1_word.char_byte == '0) begin
            // terminator inside the region
            produce              = 1'b1;
            scan_active_next     = 1'b0;
            result.allowed       = 1'b1;
            result.string_length = scan_count;
          end else begin
            scan_count_next = count_inc;
            if (count_inc >= scan_room) begin
              // region ran out before the terminator
              produce          = 1'b1;
              scan_active_next = 1'b0;
            end
          end
        end
      end
      default: begin
        // unused command, no answer
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      scan_room   <= '0;
      scan_count  <= '0;
    end else if (s1_valid && advance) begin
      scan_active <= scan_active_next;
      scan_room   <= scan_room_next;
      scan_count  <= scan_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && produce) begin
      out_word <= result;
    end
  end

  // a live scan always has room left
  assert property (@(posedge clk) disable iff (rst)
    scan_active |-> (scan_count < scan_room))
    else $error("scan count reached room while scan active");

  // access answers never carry a string length
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.answer_kind == rabc_pkg::KIND_ACCESS)
      |-> (out_word.string_length == '0))
    else $error("access answer with nonzero string length");

  // refused strings report zero length
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.allowed) |-> (out_word.string_length == '0))
    else $error("refused answer with nonzero string length");

  // input side only stalls while the input register holds a word
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held word");

endmodule
